[design/mtc_pkg.sv]
`default_nettype none
package mtc_pkg;

  // Polynomial variable width (Q0.16 duty, or grams scaled down; 18 bits covers NORM_SHIFT = 8)
  localparam int X_W = 18;
  // Horner accumulator: saturates to +-2^40, so 42 bits signed
  localparam int ACC_W = 42;
  // Intermediate sum before saturation
  localparam int SUM_W = 44;
  // Product of accumulator and variable
  localparam int PROD_W = ACC_W + X_W + 1;
  localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'(64'sd1 <<< 40);
  localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX;

  // Number of coefficient registers (x^5 .. x^0)
  localparam int NUM_COEFF = 6;
  localparam int COEFF_IDX_W = 3;

  // Fixed-point conversion constants
  localparam logic [22:0] N_TO_GF_Q16 = 23'd6682811;
  localparam logic [25:0] GF_TO_N_Q32 = 26'd42119241;
  localparam logic [17:0] THRUST_MAX_RST = 18'd216320;

  // Duty clamp limit, 1.0 in Q0.16
  localparam logic [16:0] DUTY_ONE = 17'd65536;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_THRUST_MAX = 3'd0,
    REG_COEFF_POW5 = 3'd1,
    REG_COEFF_POW4 = 3'd2,
    REG_COEFF_POW3 = 3'd3,
    REG_COEFF_POW2 = 3'd4,
    REG_COEFF_POW1 = 3'd5,
    REG_COEFF_POW0 = 3'd6
  } reg_idx_t;

  // Word travelling down the cell chain
  typedef struct packed {
    logic             vld;
    logic             cmd;
    logic [X_W-1:0]   x;
    logic [ACC_W-1:0] acc;
  } stage_t;

endpackage
`default_nettype wire

[design/mtc_prep.sv]
`default_nettype none
// Input conditioning: clamps the duty, or converts newtons to scaled grams.
module mtc_prep #(
  parameter int NORM_SHIFT = 10
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                vld_i,
  input  wire logic                cmd_i,
  input  wire logic signed [24:0]  value_i,
  input  wire logic [17:0]         thrust_max_i,
  output mtc_pkg::stage_t          q_o
);

  logic        a_vld_r, a_vld_nxt;
  logic        a_cmd_r;
  logic [16:0] a_duty_r, a_duty_nxt;
  logic [46:0] a_nprod_r, a_nprod_nxt;

  logic [47:0] g_sum;
  logic [23:0] gq8;
  logic [17:0] gq8_c;
  logic [25:0] g_shift;

  mtc_pkg::stage_t b_r, b_nxt;

  // stage A: duty clamp, newtons times grams-per-newton
  always_comb begin
    a_vld_nxt = vld_i;
    if (value_i < 0) begin
      a_duty_nxt = '0;
    end else if (value_i > $signed({8'b0, mtc_pkg::DUTY_ONE})) begin
      a_duty_nxt = mtc_pkg::DUTY_ONE;
    end else begin
      a_duty_nxt = value_i[16:0];
    end
    if (value_i < 0) begin
      a_nprod_nxt = '0;
    end else begin
      a_nprod_nxt = 47'(value_i[23:0]) * 47'(mtc_pkg::N_TO_GF_Q16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= a_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_cmd_r   <= cmd_i;
      a_duty_r  <= a_duty_nxt;
      a_nprod_r <= a_nprod_nxt;
    end
  end

  // stage B: round to Q10.8 grams, clamp, normalize into the polynomial variable
  always_comb begin
    g_sum   = 48'(a_nprod_r) + (48'd1 << 23);
    gq8     = g_sum[47:24];
    gq8_c   = (gq8 > 24'(thrust_max_i)) ? thrust_max_i : gq8[17:0];
    g_shift = {gq8_c, 8'b0} >> NORM_SHIFT;
    b_nxt.vld = a_vld_r;
    b_nxt.cmd = a_cmd_r;
    b_nxt.x   = a_cmd_r ? g_shift[mtc_pkg::X_W-1:0] : mtc_pkg::X_W'(a_duty_r);
    b_nxt.acc = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.vld <= 1'b0;
    end else if (en) begin
      b_r <= b_nxt;
    end
  end

  assign q_o = b_r;

endmodule
`default_nettype wire

[design/mtc_cell.sv]
`default_nettype none
// One Horner step: acc = sat(floor(acc * x / 2^16) + c), two register stages.
module mtc_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire mtc_pkg::stage_t d_i,
  input  wire logic [63:0]     coeff_i,
  output mtc_pkg::stage_t      q_o
);

  localparam int PW = mtc_pkg::PROD_W;
  localparam int SW = mtc_pkg::SUM_W;

  logic                       m_vld_r;
  logic                       m_cmd_r;
  logic [mtc_pkg::X_W-1:0]    m_x_r;
  logic signed [PW-1:0]       m_prod_r, m_prod_nxt;

  logic [31:0]                c_word;
  logic signed [SW-1:0]       c_ext;
  logic signed [SW-1:0]       sum;
  logic signed [SW-1:0]       sat;

  mtc_pkg::stage_t q_r;

  // multiply stage
  always_comb begin
    m_prod_nxt = $signed({{(PW-mtc_pkg::ACC_W){d_i.acc[mtc_pkg::ACC_W-1]}}, d_i.acc})
               * $signed({{(PW-mtc_pkg::X_W){1'b0}}, d_i.x});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= d_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_cmd_r  <= d_i.cmd;
      m_x_r    <= d_i.x;
      m_prod_r <= m_prod_nxt;
    end
  end

  // floor shift, add coefficient (inverse word for thrust-to-duty), saturate
  always_comb begin
    c_word = m_cmd_r ? coeff_i[63:32] : coeff_i[31:0];
    c_ext  = $signed({{(SW-32){c_word[31]}}, c_word});
    sum    = $signed(m_prod_r[SW+15:16]) + c_ext;
    if (sum > mtc_pkg::ACC_MAX) begin
      sat = mtc_pkg::ACC_MAX;
    end else if (sum < mtc_pkg::ACC_MIN) begin
      sat = mtc_pkg::ACC_MIN;
    end else begin
      sat = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r.vld <= m_vld_r;
      q_r.cmd <= m_cmd_r;
      q_r.x   <= m_x_r;
      q_r.acc <= sat[mtc_pkg::ACC_W-1:0];
    end
  end

  assign q_o = q_r;

endmodule
`default_nettype wire

[design/mtc_post.sv]
`default_nettype none
// Output conversion: grams to newtons, or accumulator to Q0.16 duty.
module mtc_post #(
  parameter int COEFF_FRAC_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire mtc_pkg::stage_t d_i,
  input  wire logic [17:0]     thrust_max_i,
  output logic                 vld_o,
  output logic [23:0]          result_o,
  output logic                 direction_o
);

  localparam int CFB = COEFF_FRAC_BITS;
  localparam int GW  = CFB + 10;
  localparam int MW  = GW + 26;
  localparam int FW  = MW + 1;
  localparam int RSH = (CFB > 16) ? CFB - 16 : 0;
  localparam int LSH = (CFB < 16) ? 16 - CFB : 0;

  logic signed [47:0] acc_ext;
  logic signed [47:0] gmax;
  logic signed [47:0] one;
  logic [GW-1:0]      g;
  logic [47:0]        d;

  logic               p_vld_r;
  logic               p_cmd_r;
  logic [MW-1:0]      p_gprod_r, p_gprod_nxt;
  logic [23:0]        p_dres_r, p_dres_nxt;

  logic [FW-1:0]      fsum;
  logic [23:0]        fres;

  logic               out_vld_r;
  logic [23:0]        out_result_r;
  logic               out_dir_r;

  // clamp and scale
  always_comb begin
    acc_ext = $signed({{(48-mtc_pkg::ACC_W){d_i.acc[mtc_pkg::ACC_W-1]}}, d_i.acc});
    gmax    = $signed(48'(thrust_max_i) << (CFB - 8));
    one     = $signed(48'd1 << CFB);
    if (acc_ext < 0) begin
      g = '0;
      d = '0;
    end else begin
      g = (acc_ext > gmax) ? gmax[GW-1:0] : acc_ext[GW-1:0];
      d = (acc_ext > one) ? one : acc_ext;
    end
    p_gprod_nxt = MW'(g) * MW'(mtc_pkg::GF_TO_N_Q32);
    p_dres_nxt  = 24'((d >> RSH) << LSH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= d_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_cmd_r   <= d_i.cmd;
      p_gprod_r <= p_gprod_nxt;
      p_dres_r  <= p_dres_nxt;
    end
  end

  // round newtons half up, select by direction
  always_comb begin
    fsum = FW'(p_gprod_r) + (FW'(1) << (CFB + 15));
    fres = 24'(fsum >> (CFB + 16));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dir_r    <= p_cmd_r;
      out_result_r <= p_cmd_r ? p_dres_r : fres;
    end
  end

  assign vld_o       = out_vld_r;
  assign result_o    = out_result_r;
  assign direction_o = out_dir_r;

endmodule
`default_nettype wire

[design/motor_thrust_curve_polynomial.sv]
`default_nettype none
// Channel  Direction  Ports
// in       input      in_valid / in_ready, in_command, in_value
// out      output     out_valid / out_ready, out_result, out_direction
// cfg      input      cfg_we, cfg_index, cfg_data (write only)
//
// One word is accepted every cycle while the output is not stalled; the pipeline has
// two prep stages, two per Horner cell for multiply and add, and two output stages.
// Synchronous active-low reset clears stage valids and loads register defaults.
// A stalled output word freezes the whole chain; in_ready follows out_ready
// while the output register is full.
module motor_thrust_curve_polynomial #(
  parameter int NORM_SHIFT      = 10,
  parameter int COEFF_FRAC_BITS = 16,
  parameter int POLY_TERMS      = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_command,
  input  wire logic signed [24:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [23:0]             out_result,
  output logic                    out_direction,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);

  logic [17:0] thrust_max_r;
  logic [63:0] coeff_r [mtc_pkg::NUM_COEFF];
  logic        en;

  mtc_pkg::stage_t chain [POLY_TERMS+1];
  logic [63:0]     cell_coeff [POLY_TERMS];

  // global advance: hold everything while the output word waits
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thrust_max_r <= mtc_pkg::THRUST_MAX_RST;
      for (int i = 0; i < mtc_pkg::NUM_COEFF; i++) begin
        coeff_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == mtc_pkg::REG_THRUST_MAX) begin
        thrust_max_r <= cfg_data[17:0];
      end else if (cfg_index inside {[mtc_pkg::REG_COEFF_POW5:mtc_pkg::REG_COEFF_POW0]}) begin
        coeff_r[mtc_pkg::COEFF_IDX_W'(cfg_index - mtc_pkg::REG_COEFF_POW5)] <= cfg_data;
      end
    end
  end

  mtc_prep #(
    .NORM_SHIFT (NORM_SHIFT)
  ) u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .vld_i        (in_valid),
    .cmd_i        (in_command),
    .value_i      (in_value),
    .thrust_max_i (thrust_max_r),
    .q_o          (chain[0])
  );

  // Horner chain, highest power first; powers above x^5 have zero coefficients
  for (genvar k = 0; k < POLY_TERMS; k++) begin : g_cell
    localparam int P = POLY_TERMS - 1 - k;
    if (P < mtc_pkg::NUM_COEFF) begin : g_coeff
      assign cell_coeff[k] = coeff_r[mtc_pkg::NUM_COEFF - 1 - P];
    end else begin : g_zero
      assign cell_coeff[k] = '0;
    end

    mtc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .d_i     (chain[k]),
      .coeff_i (cell_coeff[k]),
      .q_o     (chain[k+1])
    );
  end

  mtc_post #(
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_post (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .d_i          (chain[POLY_TERMS]),
    .thrust_max_i (thrust_max_r),
    .vld_o        (out_valid),
    .result_o     (out_result),
    .direction_o  (out_direction)
  );

endmodule
`default_nettype wire
